// File: sv/assert_macros.svh
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/ptp_pkg.sv
package ptp_pkg;

  localparam int PerimeterBits = 16;
  localparam int InBits        = 16;
  localparam int SideBits      = 15;
  localparam int MaxResults    = 64;
  localparam int CntBits       = 7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MSQ,
    S_MTEST,
    S_NTEST,
    S_GCD,
    S_DCALC,
    S_DCHK,
    S_DIV,
    S_DIVEND,
    S_SQ,
    S_PROD,
    S_NEXTN,
    S_FINISH
  } back_state_t;

endpackage

// File: sv/pythagorean_triples_by_perimeter_top.sv
// pythagorean triples of a given perimeter
// request channel: drive perimeter with start high; it is taken at a rising
// edge where start is high and busy is low. a two-entry queue holds requests
// while the generator walk runs, so busy rises only when both entries wait.
// result channel: each triple appears for one cycle with result_strobe high,
// shorter leg first, in ascending (m, n) order; last marks the final one.
// a perimeter with no triple gives one result with found low and last high.
// at most 64 triples per perimeter are given; the walk stops at the 64th.
// per m: a square and a bound check; per pair: a binary gcd, then for
// coprime pairs whose divisor fits a restoring divide, and a squaring and
// product step for a kept pair. a 16-bit perimeter near full scale walks
// about 16000 pairs.
// a result comes out when the next triple is found or the walk ends.
// the receiver cannot stall: results are never held back.
// reset clears the queue, the walk and the result strobe.
module pythagorean_triples_by_perimeter_top #(
  parameter int PERIMETER_BITS = ptp_pkg::PerimeterBits
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ptp_pkg::InBits-1:0]   perimeter,
  output logic                         busy,
  output logic                         result_strobe,
  output logic [ptp_pkg::SideBits-1:0] short_leg,
  output logic [ptp_pkg::SideBits-1:0] long_leg,
  output logic [ptp_pkg::SideBits-1:0] hypotenuse,
  output logic                         found,
  output logic                         last
);
  import ptp_pkg::*;

  logic [PERIMETER_BITS-1:0] p_in;
  logic                      q_valid;
  logic [PERIMETER_BITS-1:0] q_data;
  logic                      pop;

  assign p_in = PERIMETER_BITS'(perimeter);

  ptp_front #(
    .PERIMETER_BITS(PERIMETER_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .perimeter(p_in),
    .busy     (busy),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop)
  );

  ptp_back #(
    .PERIMETER_BITS(PERIMETER_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .result_strobe(result_strobe),
    .short_leg    (short_leg),
    .long_leg     (long_leg),
    .hypotenuse   (hypotenuse),
    .found        (found),
    .last         (last)
  );

endmodule

// File: sv/ptp_front.sv
module ptp_front #(
  parameter int PERIMETER_BITS = ptp_pkg::PerimeterBits
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [PERIMETER_BITS-1:0] perimeter,
  output logic                      busy,
  output logic                      q_valid,
  output logic [PERIMETER_BITS-1:0] q_data,
  input  logic                      pop
);
  import ptp_pkg::*;

  logic [PERIMETER_BITS-1:0] slot0;
  logic [PERIMETER_BITS-1:0] slot1;
  logic [1:0]                count;
  logic                      push;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_data  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && pop) begin
        slot0 <= perimeter;
      end else if (pop) begin
        slot0 <= slot1;
        count <= count - 2'd1;
      end else if (push) begin
        if (count == 2'd0) begin
          slot0 <= perimeter;
        end else begin
          slot1 <= perimeter;
        end
        count <= count + 2'd1;
      end
    end
  end

endmodule

// File: sv/ptp_back.sv
`include "assert_macros.svh"

module ptp_back #(
  parameter int PERIMETER_BITS = ptp_pkg::PerimeterBits
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  logic [PERIMETER_BITS-1:0]       q_data,
  output logic                            pop,
  output logic                            result_strobe,
  output logic [ptp_pkg::SideBits-1:0]    short_leg,
  output logic [ptp_pkg::SideBits-1:0]    long_leg,
  output logic [ptp_pkg::SideBits-1:0]    hypotenuse,
  output logic                            found,
  output logic                            last
);
  import ptp_pkg::*;

  localparam int PB = PERIMETER_BITS;
  localparam int MB = (PB + 1) / 2 + 1;
  localparam int SW = 2 * MB + 2;
  localparam int DW = 2 * MB + 2;
  localparam int IB = $clog2(PB + 1);

  back_state_t state;
  back_state_t state_next;

  logic [PB-1:0]       p;
  logic [MB-1:0]       m;
  logic [MB-1:0]       n;
  logic [2*MB-1:0]     mm;
  logic [2*MB-1:0]     nn;
  logic [2*MB-1:0]     mn;
  logic [MB-1:0]       ga;
  logic [MB-1:0]       gb;
  logic [DW-1:0]       d;
  logic [PB-1:0]       rem;
  logic [PB-1:0]       quo;
  logic [IB-1:0]       dstep;
  logic [CntBits-1:0]  cnt;

  logic                pend_valid;
  logic [SideBits-1:0] pend_s;
  logic [SideBits-1:0] pend_l;
  logic [SideBits-1:0] pend_h;

  logic                emit_pend;
  logic                emit_final;

  logic                gcd_done;
  logic                coprime;
  logic [PB:0]         dsh;
  logic                dge;
  logic [SW-1:0]       x1;
  logic [SW-1:0]       x2;
  logic [SW-1:0]       x3;
  logic [SideBits-1:0] k15;
  logic [SideBits-1:0] pa;
  logic [SideBits-1:0] pb;
  logic [SideBits-1:0] pc;
  logic [CntBits-1:0]  cnt_inc;

  assign gcd_done = (ga == '0) || (gb == '0);
  assign coprime  = ((ga | gb) == MB'(1));
  assign dsh      = {rem, quo[PB-1]};
  assign dge      = (dsh >= (PB+1)'(d));
  assign x1       = SW'(mm) - SW'(nn);
  assign x2       = SW'({mn, 1'b0});
  assign x3       = SW'(mm) + SW'(nn);
  assign k15      = SideBits'(quo);
  assign pa       = k15 * SideBits'(x1);
  assign pb       = k15 * SideBits'(x2);
  assign pc       = k15 * SideBits'(x3);
  assign cnt_inc  = cnt + CntBits'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (q_valid) state_next = S_MSQ;
      S_MSQ:    state_next = S_MTEST;
      S_MTEST: begin
        if ((SW'(mm) < SW'(p)) && (cnt != CntBits'(MaxResults))) begin
          state_next = S_NTEST;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_NTEST:  state_next = (n < m) ? S_GCD : S_MSQ;
      S_GCD: begin
        if (gcd_done) state_next = coprime ? S_DCALC : S_NEXTN;
      end
      S_DCALC:  state_next = S_DCHK;
      S_DCHK:   state_next = (d <= DW'(p)) ? S_DIV : S_NEXTN;
      S_DIV:    if (dstep == IB'(PB - 1)) state_next = S_DIVEND;
      S_DIVEND: state_next = (rem == '0) ? S_SQ : S_NEXTN;
      S_SQ:     state_next = S_PROD;
      S_PROD:   state_next = (cnt_inc == CntBits'(MaxResults)) ? S_FINISH : S_NEXTN;
      S_NEXTN:  state_next = S_NTEST;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    emit_pend  = 1'b0;
    emit_final = 1'b0;
    unique case (state)
      S_IDLE:   pop = q_valid;
      S_PROD:   emit_pend = pend_valid;
      S_FINISH: emit_final = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
      cnt           <= '0;
    end else begin
      state         <= state_next;
      result_strobe <= emit_pend || emit_final;
      if (emit_pend) begin
        short_leg  <= pend_s;
        long_leg   <= pend_l;
        hypotenuse <= pend_h;
        found      <= 1'b1;
        last       <= 1'b0;
      end else if (emit_final) begin
        short_leg  <= pend_valid ? pend_s : '0;
        long_leg   <= pend_valid ? pend_l : '0;
        hypotenuse <= pend_valid ? pend_h : '0;
        found      <= pend_valid;
        last       <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          p   <= q_data;
          m   <= MB'(2);
          cnt <= '0;
        end
        S_MSQ:   mm <= (2*MB)'(m) * (2*MB)'(m);
        S_MTEST: n  <= MB'(m[0]) + MB'(1);
        S_NTEST: begin
          if (n < m) begin
            ga <= m;
            gb <= n;
          end else begin
            m <= m + MB'(1);
          end
        end
        S_GCD: begin
          if (!gcd_done) begin
            if (!ga[0]) begin
              ga <= ga >> 1;
            end else if (!gb[0]) begin
              gb <= gb >> 1;
            end else if (ga >= gb) begin
              ga <= ga - gb;
            end else begin
              gb <= gb - ga;
            end
          end
        end
        S_DCALC: d <= DW'({(2*MB+1)'(m) * (2*MB+1)'(MB'(m + n)), 1'b0});
        S_DCHK: begin
          rem   <= '0;
          quo   <= p;
          dstep <= '0;
        end
        S_DIV: begin
          rem   <= dge ? PB'(dsh - (PB+1)'(d)) : PB'(dsh);
          quo   <= {quo[PB-2:0], dge};
          dstep <= dstep + IB'(1);
        end
        S_SQ: begin
          nn <= (2*MB)'(n) * (2*MB)'(n);
          mn <= (2*MB)'(m) * (2*MB)'(n);
        end
        S_PROD: begin
          pend_valid <= 1'b1;
          cnt        <= cnt_inc;
          pend_h     <= pc;
          if (x1 < x2) begin
            pend_s <= pa;
            pend_l <= pb;
          end else begin
            pend_s <= pb;
            pend_l <= pa;
          end
        end
        S_NEXTN:  n <= n + MB'(2);
        S_FINISH: pend_valid <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_empty_is_last, clk, rst, result_strobe && !found, last)
  `ASSERT_IMPL(a_idle_no_pending, clk, rst, state == S_IDLE, !pend_valid)
  `ASSERT_NEXT(a_pop_starts_walk, clk, rst, pop, state == S_MSQ)
  `ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, cnt <= CntBits'(MaxResults))

endmodule

// File: sim/pythagorean_triples_by_perimeter_top_test.sv
`timescale 1ns / 1ps

module pythagorean_triples_by_perimeter_top_test;

  typedef struct packed {
    logic [ptp_pkg::SideBits-1:0] short_leg;
    logic [ptp_pkg::SideBits-1:0] long_leg;
    logic [ptp_pkg::SideBits-1:0] hypotenuse;
    logic                         found;
    logic                         last;
  } triple_t;

  typedef struct {
    logic [ptp_pkg::InBits-1:0] perimeter;
    bit                         fixed;
    triple_t                    answer;
  } row_t;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic [ptp_pkg::InBits-1:0]   perimeter;
  logic                         busy;
  logic                         result_strobe;
  logic [ptp_pkg::SideBits-1:0] short_leg;
  logic [ptp_pkg::SideBits-1:0] long_leg;
  logic [ptp_pkg::SideBits-1:0] hypotenuse;
  logic                         found;
  logic                         last;

  triple_t expected_triples[$];
  int      mismatches;
  int      requests_sent;
  int      triples_seen;
  int      empty_answers;

  pythagorean_triples_by_perimeter_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .perimeter(perimeter),
    .busy(busy),
    .result_strobe(result_strobe),
    .short_leg(short_leg),
    .long_leg(long_leg),
    .hypotenuse(hypotenuse),
    .found(found),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic triple_t make_triple(longint unsigned s, longint unsigned l,
                                          longint unsigned h, bit f, bit e);
    triple_t t;
    t.short_leg  = s[ptp_pkg::SideBits-1:0];
    t.long_leg   = l[ptp_pkg::SideBits-1:0];
    t.hypotenuse = h[ptp_pkg::SideBits-1:0];
    t.found      = f;
    t.last       = e;
    return t;
  endfunction

  function automatic void euclid_triples(input logic [ptp_pkg::InBits-1:0] p_in,
                                         ref triple_t q[$]);
    longint unsigned p, m, n, a, b, g, r, d, k, x, y, z;
    int count;
    p = p_in & ((64'd1 << ptp_pkg::PerimeterBits) - 1);
    count = 0;
    for (m = 2; m * m < p && count < ptp_pkg::MaxResults; m++) begin
      for (n = (m & 1) + 1; n < m && count < ptp_pkg::MaxResults; n += 2) begin
        a = m;
        b = n;
        while (b != 0) begin
          r = a % b;
          a = b;
          b = r;
        end
        g = a;
        d = 2 * m * (m + n);
        if (g == 1 && p % d == 0) begin
          k = p / d;
          x = k * (m * m - n * n);
          y = k * 2 * m * n;
          z = k * (m * m + n * n);
          if (x < y) q.push_back(make_triple(x, y, z, 1'b1, 1'b0));
          else q.push_back(make_triple(y, x, z, 1'b1, 1'b0));
          count++;
        end
      end
    end
    if (count == 0) q.push_back(make_triple(0, 0, 0, 1'b0, 1'b1));
    else q[q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    triple_t got, want;
    if (!rst && result_strobe) begin
      got = '{short_leg, long_leg, hypotenuse, found, last};
      if (found) triples_seen++;
      else empty_answers++;
      if (expected_triples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_triples.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic send_request(input logic [ptp_pkg::InBits-1:0] p, input bit fixed,
                              input triple_t answer);
    triple_t q[$];
    start <= 1'b1;
    perimeter <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
    if (fixed) expected_triples.push_back(answer);
    else begin
      euclid_triples(p, q);
      foreach (q[i]) expected_triples.push_back(q[i]);
    end
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained;
    while (expected_triples.size() != 0) @(posedge clk);
  endtask

  initial begin
    row_t    rows[$];
    triple_t none;
    int      burst;
    int      sel;
    logic [ptp_pkg::InBits-1:0] p;

    none = make_triple(0, 0, 0, 1'b0, 1'b1);
    rows = '{
      '{16'd0,     1'b1, none},
      '{16'd1,     1'b1, none},
      '{16'd11,    1'b1, none},
      '{16'd12,    1'b1, make_triple(3, 4, 5, 1'b1, 1'b1)},
      '{16'd30,    1'b1, make_triple(5, 12, 13, 1'b1, 1'b1)},
      '{16'd13,    1'b1, none},
      '{16'd24,    1'b0, none},
      '{16'd60,    1'b0, none},
      '{16'd120,   1'b0, none},
      '{16'd840,   1'b0, none},
      '{16'd1000,  1'b0, none},
      '{16'd2520,  1'b0, none},
      '{16'd65535, 1'b0, none},
      '{16'd65520, 1'b0, none},
      '{16'd32768, 1'b0, none},
      '{16'd21845, 1'b0, none},
      '{16'd43690, 1'b0, none}
    };

    rst = 1'b1;
    start = 1'b0;
    perimeter = '0;
    mismatches = 0;
    requests_sent = 0;
    triples_seen = 0;
    empty_answers = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_request(rows[i].perimeter, rows[i].fixed, rows[i].answer);
      idle_gap((i % 3 == 0) ? $urandom_range(1, 12) : 0);
    end

    start <= 1'b0;
    wait_drained();
    @(posedge clk);

    for (int n = 0; n < 100; ) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst && n < 100; b++, n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 4) p = ptp_pkg::InBits'($urandom);
        else if (sel < 14) p = ptp_pkg::InBits'(12 * $urandom_range(1, 100));
        else p = ptp_pkg::InBits'($urandom_range(0, 1200));
        send_request(p, 1'b0, none);
      end
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
    end

    start <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);

    $display("%0d perimeters sent (extremes, no-triple and multi-triple cases, random)",
             requests_sent);
    $display("%0d triples and %0d empty answers checked, %0d mismatches",
             triples_seen, empty_answers, mismatches);
    if (mismatches == 0 && expected_triples.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: pythagorean_triples_by_perimeter_top.f
+incdir+sv
sv/ptp_pkg.sv
sv/ptp_front.sv
sv/ptp_back.sv
sv/pythagorean_triples_by_perimeter_top.sv
sim/pythagorean_triples_by_perimeter_top_test.sv
